// ===== design/csten_pkg.sv =====
// ----------------------------------------------------------------------------
// csten_pkg
// Shared types and constants of the case and space text encoder: transaction
// payloads, the word tracking context and the symbol burst of one text byte.
// ----------------------------------------------------------------------------
package csten_pkg;

   // largest number of symbols that one text byte can produce
   localparam int MaxSyms = 5;
   localparam int SymCntW = $clog2(MaxSyms + 1);
   localparam int SymIdxW = $clog2(MaxSyms);

   // marker codes placed in front of a word
   localparam logic [7:0] MARK_NO_SPACE  = 8'd1;
   localparam logic [7:0] MARK_ALL_CAPS  = 8'd2;
   localparam logic [7:0] MARK_FIRST_CAP = 8'd3;

   // character classes
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5a;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7a;
   localparam logic [7:0] CH_HIGH    = 8'h80;
   localparam logic [7:0] CH_CASE_OFFSET = CH_LOWER_A - CH_UPPER_A;

   // input transaction
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [7:0] symbol;
      logic       last_of_run;
      logic       stream_end;
   } rsp_type;

   // word tracking mode
   typedef enum logic [3:0] {
      MODE_NONE  = 4'b0001,
      MODE_LOWER = 4'b0010,
      MODE_CAPS  = 4'b0100,
      MODE_HELD  = 4'b1000
   } mode_type;

   // word tracking context carried from byte to byte
   typedef struct packed {
      mode_type   mode;
      logic [7:0] held_capital;
      logic       held_spaced;
      logic       space_pending;
      logic       started;
   } ctx_type;

   localparam ctx_type CtxReset = '{
      mode:          MODE_NONE,
      held_capital:  8'd0,
      held_spaced:   1'b0,
      space_pending: 1'b0,
      started:       1'b0
   };

   // symbols produced by one text byte
   typedef struct packed {
      logic [MaxSyms-1:0][7:0] syms;
      logic [SymCntW-1:0]      count;
      logic                    eos;
   } burst_type;

endpackage

// ===== design/csten_expand.sv =====
// ----------------------------------------------------------------------------
// csten_expand
// Combinational expander: from the word context and one text byte, builds the
// list of output symbols for that byte and the next word context.
// ----------------------------------------------------------------------------
module csten_expand (
   input  csten_pkg::ctx_type   ctx,
   input  csten_pkg::req_type   item,
   output csten_pkg::burst_type burst,
   output csten_pkg::ctx_type   ctx_next
);

   function automatic logic is_cap(input logic [7:0] c);
      return (c >= csten_pkg::CH_UPPER_A) && (c <= csten_pkg::CH_UPPER_Z);
   endfunction

   function automatic logic is_small(input logic [7:0] c);
      return ((c >= csten_pkg::CH_LOWER_A) && (c <= csten_pkg::CH_LOWER_Z)) ||
             (c >= csten_pkg::CH_HIGH);
   endfunction

   function automatic logic [7:0] to_small(input logic [7:0] c);
      return is_cap(c) ? c + csten_pkg::CH_CASE_OFFSET : c;
   endfunction

   // append one symbol, dropping anything past the list size
   function automatic void emit(inout csten_pkg::burst_type l, input logic [7:0] s);
      if (l.count < csten_pkg::SymCntW'(csten_pkg::MaxSyms)) begin
         l.syms[l.count[csten_pkg::SymIdxW-1:0]] = s;
         l.count = l.count + csten_pkg::SymCntW'(1);
      end
   endfunction

   // held capital opens a first-capital word
   function automatic void flush_held(inout csten_pkg::ctx_type st,
                                      inout csten_pkg::burst_type l);
      if (!st.held_spaced) begin
         emit(l, csten_pkg::MARK_NO_SPACE);
      end
      emit(l, csten_pkg::MARK_FIRST_CAP);
      emit(l, csten_pkg::CH_SPACE);
      emit(l, to_small(st.held_capital));
      st.mode = csten_pkg::MODE_NONE;
   endfunction

   // byte seen while outside any word
   function automatic void start_fresh(inout csten_pkg::ctx_type st,
                                       inout csten_pkg::burst_type l,
                                       input logic [7:0] c);
      logic spaced;
      spaced = st.space_pending || !st.started;
      if (is_small(c) || is_cap(c)) begin
         st.space_pending = 1'b0;
         if (is_small(c)) begin
            if (!spaced) begin
               emit(l, csten_pkg::MARK_NO_SPACE);
            end
            emit(l, csten_pkg::CH_SPACE);
            emit(l, c);
            st.mode = csten_pkg::MODE_LOWER;
         end else begin
            st.held_capital = c;
            st.held_spaced  = spaced;
            st.mode         = csten_pkg::MODE_HELD;
         end
      end else begin
         if (st.space_pending) begin
            emit(l, csten_pkg::CH_SPACE);
            st.space_pending = 1'b0;
         end
         if (c == csten_pkg::CH_SPACE) begin
            st.space_pending = 1'b1;
         end else begin
            emit(l, c);
         end
         st.mode = csten_pkg::MODE_NONE;
      end
   endfunction

   csten_pkg::ctx_type   st;
   csten_pkg::burst_type l;
   logic [7:0]           c;

   // expand one byte
   always_comb begin
      c       = item.in_byte;
      st      = ctx;
      l.syms  = '0;
      l.count = '0;
      l.eos   = item.end_of_stream;
      case (ctx.mode)
         csten_pkg::MODE_LOWER: begin
            if (is_small(c)) begin
               emit(l, c);
            end else begin
               start_fresh(st, l, c);
            end
         end
         csten_pkg::MODE_CAPS: begin
            if (is_cap(c)) begin
               emit(l, to_small(c));
            end else begin
               start_fresh(st, l, c);
            end
         end
         csten_pkg::MODE_HELD: begin
            if (is_cap(c)) begin
               if (!st.held_spaced) begin
                  emit(l, csten_pkg::MARK_NO_SPACE);
               end
               emit(l, csten_pkg::MARK_ALL_CAPS);
               emit(l, csten_pkg::CH_SPACE);
               emit(l, to_small(st.held_capital));
               emit(l, to_small(c));
               st.mode = csten_pkg::MODE_CAPS;
            end else begin
               flush_held(st, l);
               if (is_small(c)) begin
                  emit(l, c);
                  st.mode = csten_pkg::MODE_LOWER;
               end else begin
                  start_fresh(st, l, c);
               end
            end
         end
         default: begin
            start_fresh(st, l, c);
         end
      endcase

      // end of stream flushes whatever is held
      if (item.end_of_stream) begin
         if (st.mode == csten_pkg::MODE_HELD) begin
            flush_held(st, l);
         end
         if (st.space_pending) begin
            emit(l, csten_pkg::CH_SPACE);
         end
      end

      if (l.count != '0) begin
         st.started = 1'b1;
      end
      if (item.end_of_stream) begin
         st = csten_pkg::CtxReset;
      end
   end

   assign burst    = l;
   assign ctx_next = st;

endmodule

// ===== design/csten_outbuf.sv =====
// ----------------------------------------------------------------------------
// csten_outbuf
// Result buffer: holds the symbol burst of one byte and hands it out one
// symbol per transaction, tagging the last one of the byte and of the stream.
// ----------------------------------------------------------------------------
module csten_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  csten_pkg::burst_type burst,
   output logic                 can_load,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output csten_pkg::rsp_type   rsp_payload
);

   logic [csten_pkg::MaxSyms-1:0][7:0] syms_ff, syms_in;
   logic [csten_pkg::SymCntW-1:0]      cnt_ff, cnt_in;
   logic [csten_pkg::SymIdxW-1:0]      idx_ff, idx_in;
   logic                               eos_ff, eos_in;
   logic                               at_last;
   logic                               take;

   // current symbol position
   assign at_last   = (csten_pkg::SymCntW'(idx_ff) == cnt_ff - csten_pkg::SymCntW'(1));
   assign rsp_valid = (cnt_ff != '0);
   assign take      = rsp_valid && rsp_ready;
   assign can_load  = !rsp_valid || (take && at_last);

   assign rsp_payload.symbol      = syms_ff[idx_ff];
   assign rsp_payload.last_of_run = at_last;
   assign rsp_payload.stream_end  = at_last && eos_ff;

   // next buffer contents
   always_comb begin
      syms_in = syms_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      eos_in  = eos_ff;
      if (load) begin
         syms_in = burst.syms;
         cnt_in  = burst.count;
         idx_in  = '0;
         eos_in  = burst.eos;
      end else if (take) begin
         if (at_last) begin
            cnt_in = '0;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + csten_pkg::SymIdxW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      syms_ff <= syms_in;
      eos_ff  <= eos_in;
   end

endmodule

// ===== design/case_space_text_encoder.sv =====
// Path: an accepted byte is registered, expanded and loaded into the result buffer for rsp.
// Throughput: one byte per cycle while each byte yields at most one symbol and rsp_ready
// stays high; a byte of n symbols (up to five) holds the result buffer till all are taken.
// The result buffer, one symbol per transaction, sets the sustained rate.
// Reset: synchronous, active high; clears handshake state and word context, no
// clearing pass.
// ----------------------------------------------------------------------------
// case_space_text_encoder
// Text byte to symbol stream encoder: input register, combinational word
// expander with its context register, and a result buffer.
// ----------------------------------------------------------------------------
module case_space_text_encoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  csten_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output csten_pkg::rsp_type rsp_payload
);

   logic                 in_valid_ff, in_valid_in;
   csten_pkg::req_type   in_ff, in_in;
   csten_pkg::ctx_type   ctx_ff, ctx_in;
   csten_pkg::ctx_type   ctx_next;
   csten_pkg::burst_type burst;
   logic                 can_load;
   logic                 load;

   // input stage moves into the result buffer when it can take a burst
   assign load      = in_valid_ff && can_load;
   assign req_ready = !in_valid_ff || load;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_payload;
      end else if (load) begin
         in_valid_in = 1'b0;
      end
   end

   // word context advances with each loaded byte
   assign ctx_in = load ? ctx_next : ctx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         ctx_ff      <= csten_pkg::CtxReset;
      end else begin
         in_valid_ff <= in_valid_in;
         ctx_ff      <= ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   // expander
   csten_expand u_expand (
      .ctx      (ctx_ff),
      .item     (in_ff),
      .burst    (burst),
      .ctx_next (ctx_next)
   );

   // result buffer
   csten_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .burst       (burst),
      .can_load    (can_load),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // end of stream always flushes something
   assert property (@(posedge clock) disable iff (reset)
      load && in_ff.end_of_stream |-> burst.count != '0)
      else $error("end of stream byte produced no symbols");

   // context returns to reset after the end of a stream
   assert property (@(posedge clock) disable iff (reset)
      load && in_ff.end_of_stream |=> ctx_ff == csten_pkg::CtxReset)
      else $error("word context not cleared after end of stream");

   // a held capital has already absorbed any pending space
   assert property (@(posedge clock) disable iff (reset)
      ctx_ff.mode == csten_pkg::MODE_HELD |-> !ctx_ff.space_pending)
      else $error("space pending while a capital is held");

   // stream end only on the last symbol of a byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.stream_end |-> rsp_payload.last_of_run)
      else $error("stream end without last of run");

endmodule
